// ----- hw/rtl/vlcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlcd_pkg: shared types and constants of the DPCM frame decoder
// Status codes, phase encodings, result and geometry records.
// ----------------------------------------------------------------------------
package vlcd_pkg;

  localparam int DATA_W   = 8;
  localparam int LEN_W    = 13;  // configuration register width
  localparam int CFG_IDX_W = 2;
  localparam int PIX_W    = 14;  // pixel count field of a header
  localparam int BITS_W   = 16;  // payload bit count
  localparam int SAMP_W   = 16;  // samples left in a packet
  localparam int COL_W    = 16;  // column within a line of samples
  localparam int PITCH_W  = 16;  // samples per line
  localparam int AREA_W   = 26;  // pixels per frame

  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [LEN_W-1:0] LINE_WIDTH_RESET   = 13'd320;
  localparam logic [LEN_W-1:0] FRAME_HEIGHT_RESET = 13'd240;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_LEN  = 3'd1,
    ST_INCOMPL  = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_BAD_POS  = 3'd4,
    ST_SHORT    = 3'd5,
    ST_SIZE     = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    HP_B0, HP_B1, HP_B2, HP_B3, HP_PAY, HP_SKIP
  } hdr_phase_t;

  typedef enum logic [1:0] {
    CP_PREFIX, CP_FIRST, CP_REST
  } code_phase_t;

  typedef enum logic [1:0] {
    CS_HEAD, CS_BITS, CS_CLOSE, CS_FLUSH
  } core_state_t;

  typedef struct packed {
    logic [DATA_W-1:0] sample;
    logic              is_status;
    status_t           code;
    logic              run_end;
  } result_t;

  typedef struct packed {
    logic [PITCH_W-1:0] pitch;
    logic [AREA_W-1:0]  area;
  } geom_t;

endpackage

// ----- hw/rtl/vlcd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlcd_queue: input byte queue
// Two-entry queue that takes input beats and holds them for the decoder core.
// ----------------------------------------------------------------------------
module vlcd_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [vlcd_pkg::DATA_W-1:0] in_byte,
  input  logic                      in_last,
  output logic                      q_valid,
  output logic [vlcd_pkg::DATA_W-1:0] q_byte,
  output logic                      q_last,
  input  logic                      q_pop
);
  import vlcd_pkg::*;

  logic [DATA_W:0] mem [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;
  logic            pop;

  assign in_stall = (count == 2'd2);
  assign q_valid  = (count != 2'd0);
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;
  assign q_byte   = mem[rd_ptr][DATA_W:1];
  assign q_last   = mem[rd_ptr][0];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= {in_byte, in_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- hw/rtl/vlcd_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlcd_core: packet parser and bit-serial code decoder
// Works on the byte at the head of the queue, one payload bit per cycle when not stalled.
// ----------------------------------------------------------------------------
module vlcd_core #(
  parameter int MAX_PACKET_BYTES = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  logic [vlcd_pkg::DATA_W-1:0] q_byte,
  input  logic                        q_last,
  output logic                        q_pop,
  input  vlcd_pkg::geom_t             geom,
  input  logic                        out_ready,
  output logic                        push,
  output vlcd_pkg::result_t           push_res
);
  import vlcd_pkg::*;

  localparam int PKT_W = $clog2(MAX_PACKET_BYTES);

  core_state_t state, state_next;
  hdr_phase_t  hphase, hphase_next;
  logic [23:0] hold, hold_next;
  logic [PKT_W-1:0] pkt_left, pkt_left_next;
  logic [BITS_W-1:0] bits_left, bits_left_next;
  logic [SAMP_W-1:0] samples_left, samples_left_next;
  code_phase_t cphase, cphase_next;
  logic [4:0] clen, clen_next;
  logic [4:0] cval, cval_next;
  logic [COL_W-1:0] col, col_next;
  logic [DATA_W-1:0] recent [3];
  logic [DATA_W-1:0] recent_next [3];
  logic [AREA_W-1:0] psf, psf_next;
  logic first, first_next;
  logic zero, zero_next;
  logic [2:0] bit_idx, bit_idx_next;
  logic pend_valid;
  result_t pend;

  logic gen;
  result_t gres;
  logic byte_done, want_bits, want_close, dec_en, do_reset;
  logic go, need_push;

  // Header fields.
  logic [BITS_W-1:0] hdr_bits;
  logic [PIX_W-1:0]  hdr_pix;
  logic [1:0]        pos;
  logic [16:0]       plen_sum;
  logic [13:0]       plen;
  logic [AREA_W:0]   pix_sum;
  logic              pos_bad_mid;
  logic              pos_bad_last;

  assign hdr_bits    = {hold[7:0], q_byte};
  assign hdr_pix     = {hold[21:16], hold[15:8]};
  assign pos         = hold[23:22];
  assign plen_sum    = 17'(hdr_bits) + 17'd47;
  assign plen        = {plen_sum[16:4], 1'b0};
  assign pix_sum     = (AREA_W+1)'(psf) + (AREA_W+1)'(hdr_pix);
  assign pos_bad_mid = !first && (pos != 2'd0);
  assign pos_bad_last = (pos != 2'd1);

  // Datapath: next values of the frame state for the current step.
  always_comb begin
    logic bit_v, act, put;
    logic [4:0] pv, v, l2;
    logic [DATA_W-1:0] s;
    hphase_next       = hphase;
    hold_next         = hold;
    pkt_left_next     = pkt_left;
    bits_left_next    = bits_left;
    samples_left_next = samples_left;
    cphase_next       = cphase;
    clen_next         = clen;
    cval_next         = cval;
    col_next          = col;
    recent_next       = recent;
    psf_next          = psf;
    first_next        = first;
    zero_next         = zero;
    gen = 1'b0;
    gres = '0;
    byte_done = 1'b0;
    want_bits = 1'b0;
    want_close = 1'b0;
    dec_en = 1'b0;
    do_reset = 1'b0;
    bit_v = 1'b0;
    act = 1'b0;
    put = 1'b0;
    pv = '0;
    v = '0;
    l2 = '0;
    s = '0;

    unique case (state)
      CS_HEAD: begin
        if (q_valid) begin
          unique case (hphase)
            HP_B0, HP_B1, HP_B2: begin
              byte_done = 1'b1;
              if (q_last) begin
                gen = 1'b1; gres.is_status = 1'b1; gres.code = ST_SIZE;
                do_reset = 1'b1;
              end else begin
                hold_next = {hold[15:0], q_byte};
                hphase_next = hdr_phase_t'(hphase + 3'd1);
              end
            end
            HP_B3: begin
              byte_done = 1'b1;
              if (q_last) begin
                gen = 1'b1; gres.is_status = 1'b1; gres.code = ST_SIZE;
                do_reset = 1'b1;
              end else if (plen > MAX_PACKET_BYTES) begin
                gen = 1'b1; gres.is_status = 1'b1; gres.code = ST_BAD_LEN;
                hphase_next = HP_SKIP;
              end else if (pix_sum > (AREA_W+1)'(geom.area)) begin
                gen = 1'b1; gres.is_status = 1'b1; gres.code = ST_OVERFLOW;
                hphase_next = HP_SKIP;
              end else if (first && (pos != 2'd2)) begin
                gen = 1'b1; gres.is_status = 1'b1; gres.code = ST_BAD_POS;
                hphase_next = HP_SKIP;
              end else begin
                psf_next = AREA_W'(pix_sum);
                samples_left_next = SAMP_W'({hdr_pix, 1'b0}) + SAMP_W'(hdr_pix);
                bits_left_next = hdr_bits;
                pkt_left_next = PKT_W'(plen - 14'd4);
                cphase_next = CP_PREFIX;
                clen_next = '0;
                cval_next = '0;
                zero_next = (hdr_pix == '0);
                if (plen == 14'd4) begin
                  // An empty packet always fails: either its position or
                  // its unused sample count.
                  gen = 1'b1; gres.is_status = 1'b1;
                  gres.code = pos_bad_mid ? ST_BAD_POS : ST_SHORT;
                  hphase_next = HP_SKIP;
                end else begin
                  hphase_next = HP_PAY;
                end
              end
            end
            HP_PAY: begin
              if (pkt_left > PKT_W'(1)) begin
                if (q_last) begin
                  gen = 1'b1; gres.is_status = 1'b1; gres.code = ST_INCOMPL;
                  do_reset = 1'b1;
                  byte_done = 1'b1;
                end else begin
                  dec_en = 1'b1;
                  want_bits = 1'b1;
                end
              end else if (q_last ? pos_bad_last : pos_bad_mid) begin
                gen = 1'b1; gres.is_status = 1'b1; gres.code = ST_BAD_POS;
                byte_done = 1'b1;
                if (q_last) begin
                  do_reset = 1'b1;
                end else begin
                  hphase_next = HP_SKIP;
                end
              end else begin
                dec_en = 1'b1;
                want_bits = 1'b1;
              end
            end
            default: begin
              byte_done = 1'b1;
              do_reset = q_last;
            end
          endcase
        end
      end
      CS_BITS: begin
        dec_en = 1'b1;
        if (bit_idx == 3'd0) begin
          if (pkt_left > PKT_W'(1)) begin
            pkt_left_next = pkt_left - PKT_W'(1);
            byte_done = 1'b1;
          end else begin
            pkt_left_next = '0;
            want_close = 1'b1;
          end
        end else begin
          want_bits = 1'b1;
        end
      end
      CS_CLOSE: begin
        byte_done = 1'b1;
        if ((samples_left != '0) || zero) begin
          gen = 1'b1; gres.is_status = 1'b1; gres.code = ST_SHORT;
          if (q_last) begin
            do_reset = 1'b1;
          end else begin
            hphase_next = HP_SKIP;
          end
        end else if (q_last) begin
          gen = 1'b1; gres.is_status = 1'b1;
          gres.code = (psf == geom.area) ? ST_OK : ST_SIZE;
          do_reset = 1'b1;
        end else begin
          hphase_next = HP_B0;
          first_next = 1'b0;
        end
      end
      default: begin
      end
    endcase

    // One payload bit, most significant first.
    if (dec_en) begin
      bit_v = q_byte[bit_idx];
      act = (bits_left != '0) && (samples_left != '0);
      if (act) begin
        bits_left_next = bits_left - BITS_W'(1);
        if (cphase == CP_PREFIX) begin
          if (bit_v) begin
            if (clen != 5'd31) begin
              clen_next = clen + 5'd1;
            end
          end else if (clen == 5'd0) begin
            put = 1'b1;
            pv = '0;
          end else begin
            cphase_next = CP_FIRST;
            cval_next = '0;
          end
        end else begin
          v = cval;
          if (cphase == CP_FIRST) begin
            v = bit_v ? 5'd0
                      : (5'd1 - ((clen < 5'd5) ? (5'd1 << clen[2:0]) : 5'd0));
          end
          l2 = (clen != 5'd0) ? (clen - 5'd1) : 5'd0;
          if (bit_v && (l2 < 5'd5)) begin
            v = v + (5'd1 << l2[2:0]);
          end
          clen_next = l2;
          cval_next = v;
          cphase_next = CP_REST;
          if (l2 == 5'd0) begin
            cphase_next = CP_PREFIX;
            put = 1'b1;
            pv = v;
          end
        end
      end
      if (put) begin
        s = {pv, 3'b000};
        if (col >= COL_W'(3)) begin
          s = s + recent[0];
        end
        recent_next[0] = recent[1];
        recent_next[1] = recent[2];
        recent_next[2] = s;
        col_next = ((17'(col) + 17'd1) >= 17'(geom.pitch)) ? '0 : col + COL_W'(1);
        samples_left_next = samples_left - SAMP_W'(1);
        gen = 1'b1;
        gres.sample = s;
      end
    end

    if (do_reset) begin
      hphase_next       = HP_B0;
      hold_next         = '0;
      pkt_left_next     = '0;
      bits_left_next    = '0;
      samples_left_next = '0;
      cphase_next       = CP_PREFIX;
      clen_next         = '0;
      cval_next         = '0;
      col_next          = '0;
      recent_next[0]    = '0;
      recent_next[1]    = '0;
      recent_next[2]    = '0;
      psf_next          = '0;
      first_next        = 1'b1;
      zero_next         = 1'b0;
    end
  end

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      CS_FLUSH: state_next = CS_HEAD;
      default: begin
        if (byte_done) begin
          state_next = (pend_valid || gen) ? CS_FLUSH : CS_HEAD;
        end else if (want_bits) begin
          state_next = CS_BITS;
        end else if (want_close) begin
          state_next = CS_CLOSE;
        end
      end
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    need_push = (state == CS_FLUSH) || (gen && pend_valid);
    go = ((state != CS_HEAD) || q_valid) && (!need_push || out_ready);
    push = go && need_push;
    push_res = pend;
    push_res.run_end = (state == CS_FLUSH);
    q_pop = go && ((state == CS_FLUSH) || (byte_done && !(pend_valid || gen)));
  end

  always_ff @(posedge clk) begin
    if (go && gen) begin
      pend <= gres;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= CS_HEAD;
      pend_valid   <= 1'b0;
      bit_idx      <= 3'd7;
      hphase       <= HP_B0;
      hold         <= '0;
      pkt_left     <= '0;
      bits_left    <= '0;
      samples_left <= '0;
      cphase       <= CP_PREFIX;
      clen         <= '0;
      cval         <= '0;
      col          <= '0;
      recent[0]    <= '0;
      recent[1]    <= '0;
      recent[2]    <= '0;
      psf          <= '0;
      first        <= 1'b1;
      zero         <= 1'b0;
    end else if (go) begin
      state        <= state_next;
      if (state == CS_FLUSH) begin
        pend_valid <= 1'b0;
      end else if (gen) begin
        pend_valid <= 1'b1;
      end
      bit_idx      <= bit_idx_next;
      hphase       <= hphase_next;
      hold         <= hold_next;
      pkt_left     <= pkt_left_next;
      bits_left    <= bits_left_next;
      samples_left <= samples_left_next;
      cphase       <= cphase_next;
      clen         <= clen_next;
      cval         <= cval_next;
      col          <= col_next;
      recent       <= recent_next;
      psf          <= psf_next;
      first        <= first_next;
      zero         <= zero_next;
    end
  end

  assign bit_idx_next = (dec_en && (want_bits || (state == CS_HEAD)) && !byte_done)
                        ? (bit_idx - 3'd1) : 3'd7;

endmodule

// ----- hw/rtl/webcam_vlc_dpcm_frame_decoder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// webcam_vlc_dpcm_frame_decoder_top: packetized DPCM camera-frame decoder
// Turns a compressed frame, one byte per beat, into sample and status beats.
// ----------------------------------------------------------------------------
// The input channel (in_valid/in_stall) carries one compressed byte per beat,
// with last_byte marking the final byte of a frame. Bytes enter a two-entry
// queue, so the source is stalled only when the queue is full.
// The core walks each payload byte one code bit per cycle while the output
// register can take results; a packet's final byte then takes a close step
// for the packet checks, and a byte that produced any result takes a flush
// step to hand over its last result. Header and skipped bytes take the head
// step, plus the flush step when they produce a result. The core finishes
// one byte before it takes the next, paced by the bit-serial decode loop.
// The output channel (out_valid/out_stall) carries one result per beat:
// a decoded sample or a frame status; run_end marks the last result a byte
// caused. Results sit in an output register; while the receiver stalls, the
// core holds at the next result and the queue keeps taking bytes until full.
// A byte's first result waits in a pending register and moves to the output
// register when the byte makes its next result, or in the flush step at the
// byte's end.
// Configuration (cfg_valid/cfg_ready, always ready) writes line_width at
// index 0 and frame_height at index 1; other indexes are ignored. Writes are
// expected only while the decoder is idle.
// Synchronous reset empties the queue and output register, restores the
// width to 320 and height to 240 and starts a new frame.
// ----------------------------------------------------------------------------
module webcam_vlc_dpcm_frame_decoder_top #(
  parameter int MAX_WIDTH        = 4096,
  parameter int MAX_HEIGHT       = 4096,
  parameter int MAX_PACKET_BYTES = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     data_byte,
  input  logic                           last_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     sample_value,
  output logic                           is_status,
  output logic [2:0]                     status_code,
  output logic                           run_end,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vlcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vlcd_pkg::LEN_W-1:0]     cfg_data
);
  import vlcd_pkg::*;

  logic [LEN_W-1:0] line_width;
  logic [LEN_W-1:0] frame_height;
  logic [LEN_W-1:0] eff_w;
  logic [LEN_W-1:0] eff_h;
  geom_t            geom;

  logic              q_valid;
  logic [DATA_W-1:0] q_byte;
  logic              q_last;
  logic              q_pop;
  logic              out_ready;
  logic              push;
  result_t           push_res;
  result_t           out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= LINE_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_LINE_WIDTH) begin
        line_width <= cfg_data;
      end else if (cfg_index == REG_FRAME_HEIGHT) begin
        frame_height <= cfg_data;
      end
    end
  end

  // Clamp the geometry and register the line pitch and frame area, so the
  // multiply stays off the decode path.
  always_comb begin
    if (line_width == '0) begin
      eff_w = LEN_W'(1);
    end else if (line_width > MAX_WIDTH) begin
      eff_w = LEN_W'(MAX_WIDTH);
    end else begin
      eff_w = line_width;
    end
    if (frame_height == '0) begin
      eff_h = LEN_W'(1);
    end else if (frame_height > MAX_HEIGHT) begin
      eff_h = LEN_W'(MAX_HEIGHT);
    end else begin
      eff_h = frame_height;
    end
  end

  always_ff @(posedge clk) begin
    geom.pitch <= PITCH_W'({eff_w, 1'b0}) + PITCH_W'(eff_w);
    geom.area  <= AREA_W'(AREA_W'(eff_w) * AREA_W'(eff_h));
  end

  vlcd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (data_byte),
    .in_last  (last_byte),
    .q_valid  (q_valid),
    .q_byte   (q_byte),
    .q_last   (q_last),
    .q_pop    (q_pop)
  );

  vlcd_core #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_byte    (q_byte),
    .q_last    (q_last),
    .q_pop     (q_pop),
    .geom      (geom),
    .out_ready (out_ready),
    .push      (push),
    .push_res  (push_res)
  );

  // Output register: loads a result whenever it is empty or being taken.
  assign out_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && out_ready) begin
      out_res <= push_res;
    end
  end

  assign sample_value = out_res.sample;
  assign is_status    = out_res.is_status;
  assign status_code  = out_res.code;
  assign run_end      = out_res.run_end;

`ifndef SYNTHESIS
  // A status beat carries no sample.
  a_status_no_sample: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_status |-> sample_value == 8'd0)
    else $error("status beat with nonzero sample");

  // A sample beat carries the ok code.
  a_sample_ok_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_status |-> status_code == ST_OK)
    else $error("sample beat with nonzero status code");

  // A status is always the final result of its byte.
  a_status_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_status |-> run_end)
    else $error("status beat without run_end");
`endif

endmodule
